/* rtl/core/svcs_pkg.sv */
// Shared types, constants and helpers of the sparse voxel chunk store.
// No dependencies; every other file of the block imports this package.
package svcs_pkg;

  // Default geometry and word layout
  localparam int SVCS_BLOCK_EDGE      = 8;
  localparam int SVCS_CHUNKS_PER_SIDE = 4;
  localparam int SVCS_LEVELS          = 16;
  localparam int SVCS_TYPE_BITS       = 8;
  localparam int SVCS_META_BITS       = 8;

  // Command codes; codes above CMD_DIRTY are unknown and change nothing
  typedef enum logic [2:0] {
    CMD_READ  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_FILL  = 3'd2,
    CMD_SURF  = 3'd3,
    CMD_DIRTY = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_PLANE,
    ST_BLOCK,
    ST_WIPE,
    ST_OUT
  } state_t;

  // One finished result, handed from the controller to the output register
  typedef struct packed {
    logic [15:0] block;
    logic        inw;
    logic [3:0]  surf;
    logic        dirty;
  } res_t;

  // Address width for n entries, never below one bit
  function automatic int clog2m1(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* rtl/core/svcs_coord.sv */
// Split of one world coordinate into chunk index and offset, with range check.
// Depends on svcs_pkg; the split is a constant table built at elaboration.
module svcs_coord import svcs_pkg::*; #(
  parameter int BLOCK_EDGE      = SVCS_BLOCK_EDGE,
  parameter int CHUNKS_PER_SIDE = SVCS_CHUNKS_PER_SIDE
) (
  input  logic [5:0]                              pos,
  output logic                                    ok,
  output logic [clog2m1(CHUNKS_PER_SIDE)-1:0]     chunk,
  output logic [clog2m1(BLOCK_EDGE)-1:0]          offs
);

  localparam int CH_W   = clog2m1(CHUNKS_PER_SIDE);
  localparam int EDGE_W = clog2m1(BLOCK_EDGE);
  localparam int SIDE   = BLOCK_EDGE * CHUNKS_PER_SIDE;

  logic              tab_ok [64];
  logic [CH_W-1:0]   tab_c  [64];
  logic [EDGE_W-1:0] tab_d  [64];

  for (genvar v = 0; v < 64; v++) begin : g_tab
    localparam logic [31:0] CV = v / BLOCK_EDGE;
    localparam logic [31:0] DV = v % BLOCK_EDGE;
    assign tab_ok[v] = (v < SIDE);
    assign tab_c[v]  = CV[CH_W-1:0];
    assign tab_d[v]  = DV[EDGE_W-1:0];
  end

  assign ok    = tab_ok[pos];
  assign chunk = tab_c[pos];
  assign offs  = tab_d[pos];

endmodule

/* rtl/core/svcs_ram.sv */
// Single-port synchronous RAM with registered read.
// Depends on svcs_pkg for the default word width (SVCS_TYPE_BITS + 1).
module svcs_ram import svcs_pkg::*; #(
  parameter int WIDTH = SVCS_TYPE_BITS + 1,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/svcs_ctrl.sv */
// Command sequencer: plane and block memory accesses, plane wipe, surface scan,
// column dirty marks and the reset clearing pass. Depends on svcs_pkg.
module svcs_ctrl import svcs_pkg::*; #(
  parameter int BLOCK_EDGE      = SVCS_BLOCK_EDGE,
  parameter int CHUNKS_PER_SIDE = SVCS_CHUNKS_PER_SIDE,
  parameter int LEVELS          = SVCS_LEVELS,
  parameter int TYPE_BITS       = SVCS_TYPE_BITS,
  parameter int META_BITS       = SVCS_META_BITS
) (
  input  logic clk,
  input  logic rst,
  // incoming item, already split
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_cmd,
  input  logic [4:0]                          in_y,
  input  logic [15:0]                         in_word,
  input  logic [7:0]                          in_fill,
  input  logic                                x_ok,
  input  logic [clog2m1(CHUNKS_PER_SIDE)-1:0] cx,
  input  logic [clog2m1(BLOCK_EDGE)-1:0]      dx,
  input  logic                                z_ok,
  input  logic [clog2m1(CHUNKS_PER_SIDE)-1:0] cz,
  input  logic [clog2m1(BLOCK_EDGE)-1:0]      dz,
  // plane memory: {allocated, uniform type}
  output logic                                                 pm_we,
  output logic [2*clog2m1(CHUNKS_PER_SIDE)+clog2m1(LEVELS)-1:0] pm_addr,
  output logic [TYPE_BITS:0]                                   pm_wdata,
  input  logic [TYPE_BITS:0]                                   pm_q,
  // block memory
  output logic bm_we,
  output logic [2*clog2m1(CHUNKS_PER_SIDE)+clog2m1(LEVELS)+2*clog2m1(BLOCK_EDGE)-1:0] bm_addr,
  output logic [TYPE_BITS+META_BITS-1:0] bm_wdata,
  input  logic [TYPE_BITS+META_BITS-1:0] bm_q,
  // result
  input  logic out_free,
  output logic res_load,
  output res_t res
);

  localparam int CH_W     = clog2m1(CHUNKS_PER_SIDE);
  localparam int EDGE_W   = clog2m1(BLOCK_EDGE);
  localparam int LVL_W    = clog2m1(LEVELS);
  localparam int COL_W    = 2 * CH_W;
  localparam int CELL_W   = 2 * EDGE_W;
  localparam int PLANE_AW = COL_W + LVL_W;
  localparam int WORD_W   = TYPE_BITS + META_BITS;

  function automatic logic [15:0] to_out(input logic [WORD_W-1:0] w);
    logic [31:0] t;
    t = 32'(w);
    return t[15:0];
  endfunction

  state_t state, state_next;
  logic [PLANE_AW-1:0] clr_cnt, clr_cnt_next;
  logic [CELL_W-1:0]   wipe_cnt, wipe_cnt_next;
  logic [LVL_W-1:0]    scan_lvl, scan_lvl_next;
  logic [(2**COL_W)-1:0] dirty, dirty_next;
  logic [15:0] res_block, res_block_next;
  logic [3:0]  res_surf, res_surf_next;
  logic        res_dirty, res_dirty_next;

  // latched item
  logic [2:0]          it_cmd;
  logic [CH_W-1:0]     it_cx, it_cz;
  logic [EDGE_W-1:0]   it_dx, it_dz;
  logic [4:0]          it_y;
  logic [WORD_W-1:0]   it_word;
  logic [TYPE_BITS-1:0] it_ftype;
  logic                it_inw;

  logic [7:0]          y8;
  logic [LVL_W-1:0]    in_lvl;
  logic [31:0]         w32;
  logic [15:0]         f16;
  logic                in_inw;
  logic                accept;
  logic [COL_W-1:0]    col;
  logic [CELL_W-1:0]   cell_ix;
  logic [PLANE_AW-1:0] plane_addr;
  logic [31:0]         lvl32;
  logic                scan_chk;
  logic [TYPE_BITS-1:0] scan_type;

  assign y8     = {3'b000, in_y};
  assign in_lvl = (in_y < LEVELS) ? y8[LVL_W-1:0] : '0;
  assign w32    = {16'h0000, in_word};
  assign f16    = {8'h00, in_fill};
  assign in_inw = (in_cmd == CMD_DIRTY) ? (x_ok && z_ok) : (x_ok && z_ok && (in_y < LEVELS));
  assign accept = in_valid && in_ready;

  assign col        = {it_cz, it_cx};
  assign cell_ix    = {it_dz, it_dx};
  assign plane_addr = {col, scan_lvl};
  assign lvl32      = 32'(scan_lvl);

  always_ff @(posedge clk) begin
    if (accept) begin
      it_cmd   <= in_cmd;
      it_cx    <= cx;
      it_dx    <= dx;
      it_cz    <= cz;
      it_dz    <= dz;
      it_y     <= in_y;
      it_word  <= w32[WORD_W-1:0];
      it_ftype <= f16[TYPE_BITS-1:0];
      it_inw   <= in_inw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      dirty   <= '0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      dirty   <= dirty_next;
    end
    wipe_cnt  <= wipe_cnt_next;
    scan_lvl  <= scan_lvl_next;
    res_block <= res_block_next;
    res_surf  <= res_surf_next;
    res_dirty <= res_dirty_next;
  end

  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    wipe_cnt_next  = wipe_cnt;
    scan_lvl_next  = scan_lvl;
    dirty_next     = dirty;
    res_block_next = res_block;
    res_surf_next  = res_surf;
    res_dirty_next = res_dirty;
    pm_we    = 1'b0;
    pm_addr  = plane_addr;
    pm_wdata = '0;
    bm_we    = 1'b0;
    bm_addr  = {plane_addr, cell_ix};
    bm_wdata = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    scan_chk = 1'b0;
    scan_type = '0;

    case (state)
      ST_CLEAR: begin
        pm_we        = 1'b1;
        pm_addr      = clr_cnt;
        clr_cnt_next = clr_cnt + 1'b1;
        if (&clr_cnt) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          scan_lvl_next  = in_lvl;
          res_block_next = '0;
          res_surf_next  = '0;
          res_dirty_next = 1'b0;
          state_next     = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        // plane read goes out on the default address
        if (!it_inw || (it_cmd > CMD_DIRTY)) begin
          state_next = ST_OUT;
        end else begin
          case (it_cmd)
            CMD_FILL: begin
              pm_we           = 1'b1;
              pm_wdata        = {1'b0, it_ftype};
              dirty_next[col] = 1'b1;
              state_next      = ST_OUT;
            end
            CMD_DIRTY: begin
              res_dirty_next  = dirty[col];
              dirty_next[col] = 1'b0;
              state_next      = ST_OUT;
            end
            default: begin
              state_next = ST_PLANE;
            end
          endcase
        end
      end
      ST_PLANE: begin
        case (it_cmd)
          CMD_READ: begin
            if (pm_q[TYPE_BITS]) begin
              state_next = ST_BLOCK;
            end else begin
              res_block_next = to_out(WORD_W'(pm_q[TYPE_BITS-1:0]));
              state_next     = ST_OUT;
            end
          end
          CMD_WRITE: begin
            dirty_next[col] = 1'b1;
            if (it_dx == '0 && it_cx != '0) begin
              dirty_next[{it_cz, it_cx - CH_W'(1)}] = 1'b1;
            end
            if (it_dx == EDGE_W'(BLOCK_EDGE - 1) && it_cx != CH_W'(CHUNKS_PER_SIDE - 1)) begin
              dirty_next[{it_cz, it_cx + CH_W'(1)}] = 1'b1;
            end
            if (it_dz == '0 && it_cz != '0) begin
              dirty_next[{it_cz - CH_W'(1), it_cx}] = 1'b1;
            end
            if (it_dz == EDGE_W'(BLOCK_EDGE - 1) && it_cz != CH_W'(CHUNKS_PER_SIDE - 1)) begin
              dirty_next[{it_cz + CH_W'(1), it_cx}] = 1'b1;
            end
            if (pm_q[TYPE_BITS]) begin
              bm_we      = 1'b1;
              bm_wdata   = it_word;
              state_next = ST_OUT;
            end else if (pm_q[TYPE_BITS-1:0] != it_word[TYPE_BITS-1:0]) begin
              // allocate the plane, then wipe it to air with the new word in place
              pm_we         = 1'b1;
              pm_wdata      = {1'b1, pm_q[TYPE_BITS-1:0]};
              wipe_cnt_next = '0;
              state_next    = ST_WIPE;
            end else begin
              state_next = ST_OUT;
            end
          end
          default: begin
            if (pm_q[TYPE_BITS]) begin
              state_next = ST_BLOCK;
            end else begin
              scan_chk  = 1'b1;
              scan_type = pm_q[TYPE_BITS-1:0];
            end
          end
        endcase
      end
      ST_BLOCK: begin
        if (it_cmd == CMD_READ) begin
          res_block_next = to_out(bm_q);
          state_next     = ST_OUT;
        end else begin
          scan_chk  = 1'b1;
          scan_type = bm_q[TYPE_BITS-1:0];
        end
      end
      ST_WIPE: begin
        bm_we         = 1'b1;
        bm_addr       = {plane_addr, wipe_cnt};
        bm_wdata      = (wipe_cnt == cell_ix) ? it_word : '0;
        wipe_cnt_next = wipe_cnt + 1'b1;
        if (&wipe_cnt) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // one level of the downward surface scan
    if (scan_chk) begin
      if (scan_type != '0) begin
        res_surf_next = lvl32[3:0];
        state_next    = ST_OUT;
      end else if (scan_lvl == '0) begin
        res_surf_next = it_y[3:0];
        state_next    = ST_OUT;
      end else begin
        scan_lvl_next = scan_lvl - 1'b1;
        state_next    = ST_ISSUE;
      end
    end
  end

  assign res.block = res_block;
  assign res.inw   = it_inw;
  assign res.surf  = res_surf;
  assign res.dirty = res_dirty;

endmodule

/* rtl/core/sparse_voxel_chunk_store_top.sv */
// Top level of the sparse voxel chunk store: stream ports, coordinate split,
// plane and block memories, command sequencer and output register. Uses svcs_pkg.
//
// Channel  | Dir | Beat contents
// ---------+-----+-----------------------------------------------------------------
// s_axis   | in  | tuser: cmd; tdata: x_coord, y_coord, z_coord, block_in, fill_type
// m_axis   | out | tuser: in_world; tdata: block_out, surface_level, dirty_mark
//
// From acceptance to the result landing in the output register, each beat walks
// the sequencer states in order: fill, read-and-clear dirty, outside-world and
// unknown commands go from ISSUE to OUT; read goes ISSUE, PLANE, then BLOCK if
// the plane is allocated, then OUT; write goes ISSUE, PLANE, then WIPE over all
// cells when a uniform plane gets allocated, one word a cycle, then OUT; surface
// search repeats ISSUE, PLANE and, on an allocated level, BLOCK for each level
// it visits. The single port of each memory with its registered read sets these.
// After reset the plane memory is cleared one entry a cycle with s_axis_tready
// low. A new beat is taken while the previous result waits in the output
// register; the sequencer holds in its final state until that register drains.
module sparse_voxel_chunk_store_top import svcs_pkg::*; #(
  parameter int BLOCK_EDGE      = SVCS_BLOCK_EDGE,
  parameter int CHUNKS_PER_SIDE = SVCS_CHUNKS_PER_SIDE,
  parameter int LEVELS          = SVCS_LEVELS,
  parameter int TYPE_BITS       = SVCS_TYPE_BITS,
  parameter int META_BITS       = SVCS_META_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] x_coord, [10:6] y_coord, [16:11] z_coord, [32:17] block_in,
  // [40:33] fill_type, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] block_out, [19:16] surface_level, [20] dirty_mark, [23:21] zero
  output logic [23:0] m_axis_tdata,
  // [0] in_world
  output logic [0:0]  m_axis_tuser
);

  localparam int CH_W     = clog2m1(CHUNKS_PER_SIDE);
  localparam int EDGE_W   = clog2m1(BLOCK_EDGE);
  localparam int LVL_W    = clog2m1(LEVELS);
  localparam int PLANE_AW = 2 * CH_W + LVL_W;
  localparam int BLK_AW   = PLANE_AW + 2 * EDGE_W;
  localparam int WORD_W   = TYPE_BITS + META_BITS;

  logic              x_ok, z_ok;
  logic [CH_W-1:0]   cx, cz;
  logic [EDGE_W-1:0] dx, dz;

  logic                pm_we;
  logic [PLANE_AW-1:0] pm_addr;
  logic [TYPE_BITS:0]  pm_wdata, pm_q;
  logic                bm_we;
  logic [BLK_AW-1:0]   bm_addr;
  logic [WORD_W-1:0]   bm_wdata, bm_q;

  logic res_load;
  logic out_free;
  res_t res;

  // Split x and z into chunk and in-chunk offset
  svcs_coord #(
    .BLOCK_EDGE      (BLOCK_EDGE),
    .CHUNKS_PER_SIDE (CHUNKS_PER_SIDE)
  ) u_coord_x (
    .pos   (s_axis_tdata[5:0]),
    .ok    (x_ok),
    .chunk (cx),
    .offs  (dx)
  );

  svcs_coord #(
    .BLOCK_EDGE      (BLOCK_EDGE),
    .CHUNKS_PER_SIDE (CHUNKS_PER_SIDE)
  ) u_coord_z (
    .pos   (s_axis_tdata[16:11]),
    .ok    (z_ok),
    .chunk (cz),
    .offs  (dz)
  );

  // Per-plane state: allocated flag above the uniform type
  svcs_ram #(
    .WIDTH (TYPE_BITS + 1),
    .AW    (PLANE_AW)
  ) u_plane_mem (
    .clk   (clk),
    .we    (pm_we),
    .addr  (pm_addr),
    .wdata (pm_wdata),
    .rdata (pm_q)
  );

  // Block words of allocated planes; contents valid only after allocation wipe
  svcs_ram #(
    .WIDTH (WORD_W),
    .AW    (BLK_AW)
  ) u_block_mem (
    .clk   (clk),
    .we    (bm_we),
    .addr  (bm_addr),
    .wdata (bm_wdata),
    .rdata (bm_q)
  );

  svcs_ctrl #(
    .BLOCK_EDGE      (BLOCK_EDGE),
    .CHUNKS_PER_SIDE (CHUNKS_PER_SIDE),
    .LEVELS          (LEVELS),
    .TYPE_BITS       (TYPE_BITS),
    .META_BITS       (META_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_cmd   (s_axis_tuser),
    .in_y     (s_axis_tdata[10:6]),
    .in_word  (s_axis_tdata[32:17]),
    .in_fill  (s_axis_tdata[40:33]),
    .x_ok     (x_ok),
    .cx       (cx),
    .dx       (dx),
    .z_ok     (z_ok),
    .cz       (cz),
    .dz       (dz),
    .pm_we    (pm_we),
    .pm_addr  (pm_addr),
    .pm_wdata (pm_wdata),
    .pm_q     (pm_q),
    .bm_we    (bm_we),
    .bm_addr  (bm_addr),
    .bm_wdata (bm_wdata),
    .bm_q     (bm_q),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  // Output register: load when empty or draining this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {3'b000, res.dirty, res.surf, res.block};
      m_axis_tuser <= res.inw;
    end
  end

endmodule
